### src/sha_pkg.sv
// Shared types, constants and round-constant table for the SHA-256 hasher.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned FillW  = 6;
  localparam int unsigned CountW = 61;
  localparam int unsigned Rounds = 64;

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_COMP = 6'b001000,
    ST_FOLD = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    BSRC_DATA = 2'd0,
    BSRC_PAD  = 2'd1,
    BSRC_ZERO = 2'd2,
    BSRC_LEN  = 2'd3
  } byte_src_e;

  typedef struct packed {
    logic        shift_en;
    byte_src_e   byte_src;
    logic        count_en;
    logic        load_work;
    logic        round_en;
    logic [5:0]  round_idx;
    logic        fold;
    logic        clear_msg;
    logic [2:0]  word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
  } dp_status_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] v;
    case (r)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491; 6'd2:  v = 32'hb5c0fbcf;
      6'd3:  v = 32'he9b5dba5; 6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5; 6'd8:  v = 32'hd807aa98;
      6'd9:  v = 32'h12835b01; 6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe; 6'd14: v = 32'h9bdc06a7;
      6'd15: v = 32'hc19bf174; 6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc; 6'd20: v = 32'h2de92c6f;
      6'd21: v = 32'h4a7484aa; 6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d; 6'd26: v = 32'hb00327c8;
      6'd27: v = 32'hbf597fc7; 6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967; 6'd32: v = 32'h27b70a85;
      6'd33: v = 32'h2e1b2138; 6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb; 6'd38: v = 32'h81c2c92e;
      6'd39: v = 32'h92722c85; 6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3; 6'd44: v = 32'hd192e819;
      6'd45: v = 32'hd6990624; 6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08; 6'd50: v = 32'h2748774c;
      6'd51: v = 32'h34b0bcb5; 6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3; 6'd56: v = 32'h748f82ee;
      6'd57: v = 32'h78a5636f; 6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb; 6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/sha256_stream_hasher_top.sv
// Operation: a byte that fills a block starts a compression (load, 64 rounds,
// fold). A finish item feeds in the padding bytes and compresses the one or two
// padded blocks it needs, then 8 digest items go out.
// Throughput: 1 item per cycle inside a block, held off while the hasher pads,
// compresses or outputs; the single shared round unit does one round per cycle.
// Reset: asynchronous, active low; hash state returns to the initial values.
`timescale 1ns / 1ps
module sha256_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i,
    .out_valid_o, .out_ready_i, .word_index_o, .last_word_o,
    .cmd_o(cmd), .status_i(status)
  );

  sha_dp u_dp (
    .clk_i, .rst_ni, .data_byte_i,
    .cmd_i(cmd), .status_o(status), .digest_word_o
  );

endmodule

### src/sha_ctrl.sv
// Sequencer for absorb, padding, compression rounds and digest output.
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          word_index_o,
  output logic                last_word_o,
  output sha_pkg::dp_cmd_t    cmd_o,
  input  sha_pkg::dp_status_t status_i
);
  import sha_pkg::*;

  state_e     state_q, state_d;
  logic [5:0] round_q, round_d;
  logic [2:0] word_q, word_d;
  logic       first_q, first_d;   // next pad byte is the 0x80 marker
  logic       final_q, final_d;   // current padded block carries the length
  logic       pad_q, pad_d;       // compression belongs to padding
  logic       in_acc, out_acc, fill_end;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign fill_end = (status_i.fill == 6'd63);

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign word_index_o = word_q;
  assign last_word_o  = (word_q == 3'd7);

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    word_d  = word_q;
    first_d = first_q;
    final_d = final_q;
    pad_d   = pad_q;
    cmd_o   = '0;
    cmd_o.byte_src  = BSRC_DATA;
    cmd_o.round_idx = round_q;
    cmd_o.word_idx  = word_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!operation_i) begin
            cmd_o.shift_en = 1'b1;
            cmd_o.count_en = 1'b1;
            if (fill_end) begin
              pad_d   = 1'b0;
              state_d = ST_LOAD;
            end
          end else begin
            first_d = 1'b1;
            final_d = (status_i.fill[5:3] != 3'b111);
            pad_d   = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.shift_en = 1'b1;
        if (first_q) cmd_o.byte_src = BSRC_PAD;
        else if (final_q && status_i.fill[5:3] == 3'b111) cmd_o.byte_src = BSRC_LEN;
        else cmd_o.byte_src = BSRC_ZERO;
        first_d = 1'b0;
        if (fill_end) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_work = 1'b1;
        round_d = '0;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'(Rounds - 1)) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (final_q) begin
          word_d  = '0;
          state_d = ST_OUT;
        end else begin
          final_d = 1'b1;
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          word_d = word_q + 3'd1;
          if (last_word_o) begin
            cmd_o.clear_msg = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      word_q  <= '0;
      first_q <= 1'b0;
      final_q <= 1'b0;
      pad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      word_q  <= word_d;
      first_q <= first_d;
      final_q <= final_d;
      pad_q   <= pad_d;
    end
  end

endmodule

### src/sha_dp.sv
// Datapath: block window, message schedule, round unit and hash state.
`timescale 1ns / 1ps
module sha_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  sha_pkg::dp_cmd_t      cmd_i,
  output sha_pkg::dp_status_t   status_o,
  output logic [31:0]           digest_word_o
);
  import sha_pkg::*;

  // window word 0 is the oldest; bytes and schedule words enter at word 15
  logic [0:15][31:0]  win_q, win_d;
  logic [0:7][31:0]   work_q, work_d;
  logic [0:7][31:0]   hash_q, hash_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [511:0]       flat;
  logic [7:0]         in_byte;
  logic [63:0]        bit_len, len_sh;
  logic [31:0]        w_new, s0, s1, t1, t2, a, e;

  assign flat    = win_q;
  assign bit_len = {count_q, 3'b000};
  assign len_sh  = bit_len >> {3'(~fill_q[2:0]), 3'b000};

  always_comb begin
    case (cmd_i.byte_src)
      BSRC_DATA: in_byte = data_byte_i;
      BSRC_PAD:  in_byte = PadByte;
      BSRC_LEN:  in_byte = len_sh[7:0];
      default:   in_byte = 8'h00;
    endcase
  end

  assign s0    = ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3);
  assign s1    = ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10);
  assign w_new = s1 + win_q[9] + s0 + win_q[0];

  assign a  = work_q[0];
  assign e  = work_q[4];
  assign t1 = work_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
            + ((e & work_q[5]) ^ (~e & work_q[6])) + round_k(cmd_i.round_idx) + win_q[0];
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
            + ((a & work_q[1]) ^ (a & work_q[2]) ^ (work_q[1] & work_q[2]));

  always_comb begin
    win_d   = win_q;
    work_d  = work_q;
    hash_d  = hash_q;
    fill_d  = fill_q;
    count_d = count_q;
    if (cmd_i.shift_en) begin
      win_d  = {flat[503:0], in_byte};
      fill_d = fill_q + 6'd1;
    end
    if (cmd_i.count_en) count_d = count_q + 61'd1;
    if (cmd_i.load_work) work_d = hash_q;
    if (cmd_i.round_en) begin
      win_d = {flat[479:0], w_new};
      work_d = {t1 + t2, work_q[0], work_q[1], work_q[2],
                work_q[3] + t1, work_q[4], work_q[5], work_q[6]};
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) hash_d[i] = hash_q[i] + work_q[i];
    end
    if (cmd_i.clear_msg) begin
      for (int i = 0; i < 8; i++) hash_d[i] = init_h(3'(i));
      fill_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= init_h(3'(i));
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      hash_q  <= hash_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    work_q <= work_d;
  end

  assign status_o.fill = fill_q;
  assign digest_word_o = hash_q[cmd_i.word_idx];

endmodule

### src/sha_checker.sv
// Port-level assertions for the SHA-256 hasher and their bind.
`timescale 1ns / 1ps
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o)) else $error("stalled digest item changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last flag off the final word");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while digest pending");

  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest word sequence broken");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> !out_valid_o && in_ready_o)
    else $error("no return to idle after digest");

endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (.*);

### bench/sha256_stream_hasher_top_tb.sv
// Self-checking bench for the byte-stream SHA-256 hasher with a digest scoreboard.
`timescale 1ns / 1ps

class digest_scoreboard;
  logic [31:0] hash_st[8];
  logic [7:0]  blk[64];
  logic [5:0]  fill;
  logic [60:0] msg_len;
  logic [31:0] exp_word[$];
  logic [2:0]  exp_idx[$];
  logic        exp_last[$];
  int          errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    hash_st[0] = 32'h6a09e667; hash_st[1] = 32'hbb67ae85;
    hash_st[2] = 32'h3c6ef372; hash_st[3] = 32'ha54ff53a;
    hash_st[4] = 32'h510e527f; hash_st[5] = 32'h9b05688c;
    hash_st[6] = 32'h1f83d9ab; hash_st[7] = 32'h5be0cd19;
    fill = '0;
    msg_len = '0;
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           sha_pkg::round_k(r[5:0]) + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  // note one accepted input item
  function void note_item(logic op, logic [7:0] byte_v);
    logic [63:0] bits;
    int i;
    if (!op) begin
      blk[fill] = byte_v;
      fill++;
      msg_len++;
      if (fill == 0) compress();
      return;
    end
    bits = {msg_len, 3'b000};
    i = fill;
    blk[i++] = sha_pkg::PadByte;
    if (i > 56) begin
      while (i < 64) blk[i++] = 8'h00;
      compress();
      i = 0;
    end
    while (i < 56) blk[i++] = 8'h00;
    for (int k = 0; k < 8; k++) blk[56+k] = bits[63-8*k -: 8];
    compress();
    for (int k = 0; k < 8; k++) begin
      exp_word.push_back(hash_st[k]);
      exp_idx.push_back(k[2:0]);
      exp_last.push_back(k == 7);
    end
    restart();
  endfunction

  function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
    logic [31:0] ew;
    logic [2:0]  ei;
    logic        el;
    if (exp_word.size() == 0) begin
      $display("%0t: unexpected digest word %h idx %0d", $time, word, idx);
      errors++;
      return;
    end
    ew = exp_word.pop_front();
    ei = exp_idx.pop_front();
    el = exp_last.pop_front();
    if (word !== ew) begin
      $display("%0t: digest_word exp %h got %h", $time, ew, word);
      errors++;
    end
    if (idx !== ei) begin
      $display("%0t: word_index exp %0d got %0d", $time, ei, idx);
      errors++;
    end
    if (last !== el) begin
      $display("%0t: last_word exp %0b got %0b", $time, el, last);
      errors++;
    end
  endfunction

  function int pending();
    return exp_word.size();
  endfunction
endclass

module sha256_stream_hasher_top_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  digest_scoreboard sb = new();
  bit calm = 1'b0;      // no random idling on either side while set
  bit out_done = 1'b0;
  int n_sent = 0;

  sha256_stream_hasher_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sender: offer one item, hold until taken; valid drops only while idling
  task automatic send_item(logic op, logic [7:0] byte_v);
    if (!calm) begin
      while ($urandom_range(99) < 16) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    data_byte_i <= byte_v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, byte_v);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom_range(255)));
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    while (!out_done) begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 1200 && cyc < 1600) out_ready_i <= 1'b0;
      else out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(digest_word_o, word_index_o, last_word_o);

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: empty message, byte extremes, padding boundaries, finish with data set
    send_item(1'b1, 8'hff);
    send_item(1'b0, 8'h00); send_item(1'b0, 8'hff); send_item(1'b1, 8'h00);
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    send_item(1'b1, 8'h5a);
    while (n_sent < 480) begin
      int len;
      calm = (n_sent >= 300 && n_sent < 380);
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = 55 + $urandom_range(9);
        2:       len = 100 + $urandom_range(40);
        default: len = $urandom_range(20);
      endcase
      send_message(len);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    out_done = 1'b1;
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

### sim.f
src/sha_pkg.sv
src/sha_ctrl.sv
src/sha_dp.sv
src/sha256_stream_hasher_top.sv
src/sha_checker.sv
bench/sha256_stream_hasher_top_tb.sv
